@@ sv/vqe_pkg.sv @@
// ----------------------------------------------------------------------------
// vqe_pkg
// Shared types and constants of the vector quantization encoder: field
// widths, command and register codes, cell control and search token.
// ----------------------------------------------------------------------------
`default_nettype none

package vqe_pkg;

    // field widths
    localparam int IDX_W  = 8;
    localparam int POS_W  = 6;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 22;
    localparam int ENT_W  = 9;
    localparam int LEN_W  = 7;
    localparam int CFG_W  = 9;

    // largest distance a sum may hold, sums saturate here
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // input word commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic REG_CODEBOOK_ENTRIES = 1'b0;
    localparam logic REG_BLOCK_LENGTH     = 1'b1;

    // control state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_entry;
        logic [PIX_W-1:0] wr_data;
        logic             rd_en;
        logic [POS_W-1:0] addr;
        logic             upd_en;
        logic             upd_clear;
        logic [PIX_W-1:0] upd_pixel;
    } cell_ctrl_t;

    // running best, handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] distance;
    } token_t;

endpackage

`default_nettype wire

@@ sv/vqe_ram.sv @@
// ----------------------------------------------------------------------------
// vqe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/vqe_cell.sv @@
// ----------------------------------------------------------------------------
// vqe_cell
// One codeword cell: holds the codeword in a small RAM and its running
// squared distance, and takes part in the nearest-codeword compare chain.
// ----------------------------------------------------------------------------
`default_nettype none

module vqe_cell #(
    parameter int CELL_ID   = 0,
    parameter int DIMENSION = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cell_active,
    input  wire vqe_pkg::cell_ctrl_t ctrl,
    input  wire vqe_pkg::token_t     tok_in,
    output vqe_pkg::token_t          tok_out
);
    import vqe_pkg::*;

    localparam int AW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic [PIX_W-1:0] code_elem;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [PIX_W-1:0] diff;
    logic [15:0]      sq;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   total;
    logic             take;
    logic             tok_valid_reg;
    logic [IDX_W-1:0] tok_idx_reg, tok_idx_next;
    logic [SUM_W-1:0] tok_dist_reg, tok_dist_next;

    // codeword storage
    vqe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DIMENSION)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.wr_en && (ctrl.wr_entry == MY_IDX)),
        .waddr (AW'(ctrl.addr)),
        .wdata (ctrl.wr_data),
        .re    (ctrl.rd_en),
        .raddr (AW'(ctrl.addr)),
        .rdata (code_elem)
    );

    // squared difference and saturating accumulate
    always_comb begin
        diff  = (ctrl.upd_pixel > code_elem) ? (ctrl.upd_pixel - code_elem)
                                             : (code_elem - ctrl.upd_pixel);
        sq    = {8'b0, diff} * {8'b0, diff};
        base  = ctrl.upd_clear ? '0 : sum_reg;
        total = {1'b0, base} + {{(SUM_W + 1 - 16){1'b0}}, sq};
        sum_next = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.upd_en) begin
            sum_reg <= sum_next;
        end
    end

    // compare against the best handed in, strict less keeps lowest index
    always_comb begin
        take          = cell_active && (sum_reg < tok_in.distance);
        tok_idx_next  = take ? MY_IDX  : tok_in.idx;
        tok_dist_next = take ? sum_reg : tok_in.distance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in.valid) begin
            tok_idx_reg  <= tok_idx_next;
            tok_dist_reg <= tok_dist_next;
        end
    end

    assign tok_out = '{valid: tok_valid_reg, idx: tok_idx_reg, distance: tok_dist_reg};

endmodule

`default_nettype wire

@@ sv/vq_nearest_codeword_encoder.sv @@
// ----------------------------------------------------------------------------
// vq_nearest_codeword_encoder
// Full-search vector quantization encoder built as a row of codeword cells.
// ----------------------------------------------------------------------------
// Codebook writes, pixels outside the block and pixels that do not end a
// block are taken back to back: every cell reads its codeword element at
// the pixel's position in the accept cycle and adds the squared difference
// in the next, while the next word is already taken. After a block's last
// pixel, s_ready is low while the running best walks the compare chain of
// NUM_CELLS = min(MAX_CODEWORDS, 256) cells, one cell per cycle. A result
// waits in the output register while new words are taken; lowest index wins ties.
// ----------------------------------------------------------------------------
`default_nettype none

module vq_nearest_codeword_encoder #(
    parameter int MAX_CODEWORDS = 256,
    parameter int MAX_DIMENSION = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // config write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [vqe_pkg::CFG_W-1:0]  cfg_data,
    // input words
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_cmd,
    input  wire logic [vqe_pkg::IDX_W-1:0]  s_entry_index,
    input  wire logic [vqe_pkg::POS_W-1:0]  s_element_index,
    input  wire logic [vqe_pkg::PIX_W-1:0]  s_sample_value,
    // result words
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [vqe_pkg::IDX_W-1:0]  m_best_index,
    output logic      [vqe_pkg::SUM_W-1:0]  m_best_distance
);
    import vqe_pkg::*;

    localparam int NUM_CELLS = (MAX_CODEWORDS < 256) ? MAX_CODEWORDS : 256;
    localparam logic [ENT_W-1:0] ENTRIES_MAX = ENT_W'(NUM_CELLS);
    localparam logic [8:0]       LEN_MAX     = 9'(MAX_DIMENSION);

    state_t           state_reg, state_next;
    logic [ENT_W-1:0] cfg_entries_reg;
    logic [LEN_W-1:0] cfg_length_reg;
    logic [ENT_W-1:0] n_eff;
    logic [8:0]       len_eff;
    logic [8:0]       pos_ext;
    logic             accept;
    logic             pix_ok;
    logic             wr_ok;
    logic             item_last_reg;
    logic             item_clear_reg;
    logic [PIX_W-1:0] item_pixel_reg;
    logic             start_reg, start_next;
    logic             upd_en;
    logic             out_load;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_idx_reg;
    logic [SUM_W-1:0] m_dist_reg;
    cell_ctrl_t       ctrl;
    token_t           tok [0:NUM_CELLS];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_entries_reg <= 9'd256;
            cfg_length_reg  <= 7'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CODEBOOK_ENTRIES: cfg_entries_reg <= cfg_data;
                REG_BLOCK_LENGTH:     cfg_length_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective codebook size and block length
    always_comb begin
        if (cfg_entries_reg == '0) begin
            n_eff = ENT_W'(1);
        end else if (cfg_entries_reg > ENTRIES_MAX) begin
            n_eff = ENTRIES_MAX;
        end else begin
            n_eff = cfg_entries_reg;
        end
        if (cfg_length_reg == '0) begin
            len_eff = 9'd1;
        end else if ({2'b0, cfg_length_reg} > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = {2'b0, cfg_length_reg};
        end
    end

    // input word decode
    assign accept  = s_valid && s_ready;
    assign pos_ext = {3'b0, s_element_index};
    assign pix_ok  = (s_cmd == CMD_PIXEL) && (pos_ext < len_eff);
    assign wr_ok   = (s_cmd == CMD_WRITE) && (pos_ext < LEN_MAX);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && pix_ok) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (item_last_reg) begin
                    state_next = ST_SEARCH;
                end else if (accept && pix_ok) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (tok[NUM_CELLS].valid) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = 1'b0;
        upd_en     = 1'b0;
        start_next = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_UPDATE: begin
                s_ready    = !item_last_reg;
                upd_en     = 1'b1;
                start_next = item_last_reg;
            end
            ST_SEARCH: ;
            ST_DRAIN: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            item_last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            if (accept && pix_ok) begin
                item_last_reg <= (pos_ext == (len_eff - 9'd1));
            end
        end
    end

    // pixel held for the accumulate cycle
    always_ff @(posedge aclk) begin
        if (accept && pix_ok) begin
            item_clear_reg <= (s_element_index == '0);
            item_pixel_reg <= s_sample_value;
        end
    end

    // broadcast to the cells
    always_comb begin
        ctrl.wr_en     = accept && wr_ok;
        ctrl.wr_entry  = s_entry_index;
        ctrl.wr_data   = s_sample_value;
        ctrl.rd_en     = accept && pix_ok;
        ctrl.addr      = s_element_index;
        ctrl.upd_en    = upd_en;
        ctrl.upd_clear = item_clear_reg;
        ctrl.upd_pixel = item_pixel_reg;
    end

    // head of the compare chain: index 0 at the largest distance
    assign tok[0] = '{valid: start_reg, idx: '0, distance: SUM_MAX};

    // row of codeword cells
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vqe_cell #(
            .CELL_ID   (k),
            .DIMENSION (MAX_DIMENSION)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_active (ENT_W'(k) < n_eff),
            .ctrl        (ctrl),
            .tok_in      (tok[k]),
            .tok_out     (tok[k+1])
        );
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg  <= tok[NUM_CELLS].idx;
            m_dist_reg <= tok[NUM_CELLS].distance;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_best_index    = m_idx_reg;
    assign m_best_distance = m_dist_reg;

endmodule

`default_nettype wire

@@ sv/vqe_checker.sv @@
// ----------------------------------------------------------------------------
// vqe_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vqe_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       s_cmd,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [vqe_pkg::IDX_W-1:0]  m_best_index,
    input wire logic [vqe_pkg::SUM_W-1:0]  m_best_distance
);
    import vqe_pkg::*;

    // reset empties the output register
    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_index)
                                && $stable(m_best_distance))
        else $error("result word changed while stalled");

    // a new result only appears after the search held off input words
    a_result_after_search : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word without a preceding search");

    // a codebook write never stalls the next word
    a_write_keeps_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_WRITE) |=> s_ready)
        else $error("input stalled after a codebook write");

endmodule

bind vq_nearest_codeword_encoder vqe_checker u_vqe_checker (.*);

`default_nettype wire

@@ test/vq_nearest_codeword_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// vq_nearest_codeword_encoder_tb
// Self-checking bench for the full-search vector quantization encoder. A
// compact codebook region is loaded first, then directed blocks, a saturating
// block and random phases under several register settings run through the
// block. A scoreboard class tracks the codebook and the per-codeword distance
// sums, predicts each nearest codeword and checks every result word in order.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vqe_pkg::*;

    localparam int NUM_CODEWORDS  = 256;
    localparam int NUM_POSITIONS  = 64;
    localparam int LOAD_ENTRIES   = 16;
    localparam int LOAD_POSITIONS = 8;
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_BUDGET   = 24;
    localparam int NUM_PHASES     = 6;
    localparam int CYCLE_LIMIT    = 1500000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] distance;
    } match_t;

    // codebook, distance sums and the nearest-codeword results still owed
    class nearest_match_board;
        logic [PIX_W-1:0] codewords [NUM_CODEWORDS][NUM_POSITIONS];
        int               sums [NUM_CODEWORDS];
        logic [ENT_W-1:0] entries_reg;
        logic [LEN_W-1:0] length_reg;
        match_t           expected_matches [$];
        int               errors;
        int               words_seen;
        int               matches_seen;

        function new();
            entries_reg  = 9'd256;
            length_reg   = 7'd16;
            errors       = 0;
            words_seen   = 0;
            matches_seen = 0;
            foreach (sums[c]) sums[c] = 0;
            foreach (codewords[c, p]) codewords[c][p] = '0;
        endfunction

        function int eff_entries();
            int n;
            n = entries_reg;
            if (n == 0) n = 1;
            if (n > NUM_CODEWORDS) n = NUM_CODEWORDS;
            return n;
        endfunction

        function int eff_length();
            int n;
            n = length_reg;
            if (n == 0) n = 1;
            if (n > NUM_POSITIONS) n = NUM_POSITIONS;
            return n;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_CODEBOOK_ENTRIES) begin
                entries_reg = data[ENT_W-1:0];
            end else begin
                length_reg = data[LEN_W-1:0];
            end
        endfunction

        // accepted input word: codebook write or pixel
        function void note_word(logic cmd, logic [IDX_W-1:0] entry,
                                logic [POS_W-1:0] pos, logic [PIX_W-1:0] val);
            int     len;
            int     n;
            int     d;
            int     s;
            int     best;
            int     best_sum;
            match_t m;
            words_seen++;
            if (cmd == CMD_WRITE) begin
                codewords[entry][pos] = val;
                return;
            end
            len = eff_length();
            if (pos >= len) return;
            // position zero restarts every sum
            if (pos == 0) begin
                foreach (sums[c]) sums[c] = 0;
            end
            foreach (sums[c]) begin
                d = int'(val) - int'(codewords[c][pos]);
                s = sums[c] + d * d;
                if (s > int'(SUM_MAX)) s = int'(SUM_MAX);
                sums[c] = s;
            end
            if (pos != len - 1) return;
            // search active codewords, lowest index wins ties
            n = eff_entries();
            best = 0;
            best_sum = sums[0];
            for (int c = 1; c < n; c++) begin
                if (sums[c] < best_sum) begin
                    best_sum = sums[c];
                    best = c;
                end
            end
            m.idx      = IDX_W'(best);
            m.distance = SUM_W'(best_sum);
            expected_matches.insert(expected_matches.size(), m);
        endfunction

        function void check_match(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] distance);
            match_t m;
            matches_seen++;
            if (expected_matches.size() == 0) begin
                $error("unexpected result word: best_index %0d, best_distance %0d",
                       idx, distance);
                errors++;
                return;
            end
            m = expected_matches.pop_front();
            if (idx !== m.idx) begin
                $error("best_index mismatch: expected %0d, actual %0d", m.idx, idx);
                errors++;
            end
            if (distance !== m.distance) begin
                $error("best_distance mismatch: expected %0d, actual %0d",
                       m.distance, distance);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic [IDX_W-1:0]   s_entry_index;
    logic [POS_W-1:0]   s_element_index;
    logic [PIX_W-1:0]   s_sample_value;
    logic               m_valid;
    logic               m_ready;
    logic [IDX_W-1:0]   m_best_index;
    logic [SUM_W-1:0]   m_best_distance;

    nearest_match_board board = new();

    bit send_calm    = 1'b0;
    bit take_calm    = 1'b0;
    bit filling      = 1'b0;
    bit hold_request = 1'b0;
    int phase_count  = 0;
    int cfg_writes   = 0;
    int cycle_count  = 0;

    vq_nearest_codeword_encoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_entry_index   (s_entry_index),
        .s_element_index (s_element_index),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_best_index    (m_best_index),
        .m_best_distance (m_best_distance)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, board.expected_matches.size());
            $display("** vq_nearest_codeword_encoder: FAILED **");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    // offer one input word, valid is left high after acceptance
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] entry,
                             input logic [POS_W-1:0] pos, input logic [PIX_W-1:0] val);
        int gap;
        if (!filling && $urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = (filling || send_calm) ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_entry_index   <= entry;
        s_element_index <= pos;
        s_sample_value  <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (cmd == CMD_WRITE || pos < board.eff_length()) phase_count++;
        board.note_word(cmd, entry, pos, val);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        board.set_register(idx, data);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every owed result and for the block to go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
                stall = take_calm ? 0 : $urandom_range(0, 5);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_match(m_best_index, m_best_distance);
        end
    end

    // stimulus
    initial begin
        int               n;
        int               len;
        int               i;
        int               j;
        int               k;
        int               p;
        int               r;
        logic [CFG_W-1:0] ent_data;
        logic [CFG_W-1:0] len_data;

        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_CODEBOOK_ENTRIES;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_cmd           = CMD_WRITE;
        s_entry_index   = '0;
        s_element_index = '0;
        s_sample_value  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // load the first codewords in full and position zero of all others;
        // wide searches then only run one-pixel blocks at position zero, so
        // no active codeword ever sums an unwritten element
        filling = 1'b1;
        for (i = 0; i < LOAD_ENTRIES; i++) begin
            for (p = 0; p < LOAD_POSITIONS; p++) begin
                send_word(CMD_WRITE, IDX_W'(i), POS_W'(p), draw_sample());
            end
        end
        for (i = LOAD_ENTRIES; i < NUM_CODEWORDS; i++) begin
            send_word(CMD_WRITE, IDX_W'(i), 6'd0, draw_sample());
        end
        filling = 1'b0;
        settle();

        // four codewords of two pixels each
        write_register(REG_CODEBOOK_ENTRIES, 9'd4);
        write_register(REG_BLOCK_LENGTH, 9'd2);
        send_word(CMD_WRITE, 8'd0, 6'd0, 8'd200);
        send_word(CMD_WRITE, 8'd0, 6'd1, 8'd200);
        send_word(CMD_WRITE, 8'd1, 6'd0, 8'd0);
        send_word(CMD_WRITE, 8'd1, 6'd1, 8'd255);
        send_word(CMD_WRITE, 8'd2, 6'd0, 8'd0);
        send_word(CMD_WRITE, 8'd2, 6'd1, 8'd255);
        send_word(CMD_WRITE, 8'd3, 6'd0, 8'd255);
        send_word(CMD_WRITE, 8'd3, 6'd1, 8'd0);
        // exact tie between codewords 1 and 2
        send_word(CMD_PIXEL, 8'hFF, 6'd0, 8'd0);
        send_word(CMD_PIXEL, 8'h00, 6'd1, 8'd255);
        // pixel past the end of the block is dropped
        send_word(CMD_PIXEL, 8'hA5, 6'd63, 8'd255);
        // extreme pixels, then the last position again without a restart
        send_word(CMD_PIXEL, 8'h5A, 6'd0, 8'd255);
        send_word(CMD_PIXEL, 8'h5A, 6'd1, 8'd0);
        send_word(CMD_PIXEL, 8'hC3, 6'd1, 8'd0);
        // codebook rewrite in the middle of a block
        send_word(CMD_PIXEL, 8'h3C, 6'd0, 8'd0);
        send_word(CMD_WRITE, 8'd0, 6'd1, 8'd255);
        send_word(CMD_PIXEL, 8'h3C, 6'd1, 8'd255);
        settle();

        // zero in both registers acts as one
        write_register(REG_CODEBOOK_ENTRIES, 9'd0);
        write_register(REG_BLOCK_LENGTH, 9'd0);
        send_word(CMD_PIXEL, 8'h81, 6'd0, 8'd128);
        send_word(CMD_PIXEL, 8'h7E, 6'd1, 8'd128);
        settle();

        // repeated positions push the only codeword's sum into saturation
        write_register(REG_CODEBOOK_ENTRIES, 9'd1);
        write_register(REG_BLOCK_LENGTH, 9'd64);
        send_word(CMD_WRITE, 8'd0, 6'd1, 8'd0);
        for (i = 0; i < LOAD_ENTRIES; i++) begin
            send_word(CMD_WRITE, IDX_W'(i), 6'd63, (i == 0) ? 8'd0 : draw_sample());
        end
        send_word(CMD_PIXEL, IDX_W'($urandom), 6'd0, draw_sample());
        repeat (66) send_word(CMD_PIXEL, IDX_W'($urandom), 6'd1, 8'd255);
        send_word(CMD_PIXEL, IDX_W'($urandom), 6'd63, 8'd255);
        settle();

        // random phases, one register setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    ent_data = CFG_W'(LOAD_ENTRIES);
                    len_data = CFG_W'(LOAD_POSITIONS);
                end
                1: begin
                    ent_data = 9'd1;
                    len_data = 9'd1;
                end
                2: begin
                    ent_data = CFG_W'($urandom_range(2, LOAD_ENTRIES));
                    len_data = CFG_W'($urandom_range(2, 4));
                end
                3: begin
                    ent_data = CFG_W'($urandom_range(257, 511));
                    len_data = {2'($urandom), 7'd1};
                end
                4: begin
                    ent_data = 9'd0;
                    len_data = CFG_W'($urandom_range(2, LOAD_POSITIONS));
                end
                default: begin
                    ent_data = CFG_W'($urandom_range(LOAD_ENTRIES + 1, 256));
                    len_data = {2'($urandom), 7'd0};
                end
            endcase
            write_register(REG_CODEBOOK_ENTRIES, ent_data);
            write_register(REG_BLOCK_LENGTH, len_data);
            // long output hold-off while input keeps coming
            if (ph == 2) hold_request = 1'b1;
            n = board.eff_entries();
            len = board.eff_length();
            phase_count = 0;
            while (phase_count < PHASE_BUDGET) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    // well-formed block, now and then a codebook write inside
                    for (p = 0; p < len; p++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_word(CMD_WRITE, IDX_W'($urandom_range(0, n - 1)),
                                      POS_W'($urandom_range(p, len - 1)), draw_sample());
                        end
                        send_word(CMD_PIXEL, IDX_W'($urandom), POS_W'(p), draw_sample());
                    end
                end else if (r < 75) begin
                    // copy one codeword onto another so their distances tie
                    i = $urandom_range(0, n - 1);
                    j = $urandom_range(0, n - 1);
                    for (p = 0; p < len; p++) begin
                        send_word(CMD_WRITE, IDX_W'(j), POS_W'(p), board.codewords[i][p]);
                    end
                end else if (r < 85) begin
                    // broken block: skipped and repeated positions
                    k = $urandom_range(1, len + 2);
                    for (i = 0; i < k; i++) begin
                        if (i == k - 1 && $urandom_range(0, 1) == 1) p = len - 1;
                        else p = $urandom_range(0, len - 1);
                        send_word(CMD_PIXEL, IDX_W'($urandom), POS_W'(p), draw_sample());
                    end
                end else if (r < 95) begin
                    // scattered codebook writes
                    k = $urandom_range(1, 4);
                    repeat (k) begin
                        send_word(CMD_WRITE, IDX_W'($urandom), POS_W'($urandom),
                                  draw_sample());
                    end
                end else begin
                    // stray pixel at any position
                    send_word(CMD_PIXEL, IDX_W'($urandom), POS_W'($urandom), draw_sample());
                end
            end
            settle();
        end

        $display("covered %0d input words, %0d result words, %0d register writes",
                 board.words_seen, board.matches_seen, cfg_writes);
        $display("sizes from one to 256 codewords, blocks of one to 64, one long output stall");
        if (board.errors == 0 && board.expected_matches.size() == 0) begin
            $display("** vq_nearest_codeword_encoder: PASSED **");
        end else begin
            $display("** vq_nearest_codeword_encoder: FAILED **");
        end
        $finish;
    end

endmodule
